// ----- src/cda_pkg.sv -----
// Shared types, codes and calendar helper functions for the date arithmetic block.
// No dependencies; every other file in src but cda_chk imports this package.
package cda_pkg;

  localparam int NW = 23;   // day numbers and month counts fit in 23 bits
  localparam int SW = 25;   // signed working width for sums with the amount

  typedef enum logic [2:0] {
    REQ_LOAD   = 3'd0,
    REQ_DAYS   = 3'd1,
    REQ_MONTHS = 3'd2,
    REQ_YEARS  = 3'd3,
    REQ_NEXTWD = 3'd4
  } req_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_BADDATE = 2'd1,
    ST_RANGE   = 2'd2
  } status_t;

  typedef enum logic [4:0] {
    S_IDLE, S_DISPATCH, S_LOAD, S_YADD, S_DN_ADD, S_DN_NEXT, S_RANGE,
    S_DIV_YR, S_WAIT_YR, S_YEAR, S_MWALK, S_DIV_WD, S_WAIT_WD, S_SKIP,
    S_MT, S_MCHK, S_DIV_MON, S_WAIT_MON, S_MSET, S_OUT_DN, S_DIV_OWD,
    S_WAIT_OWD, S_SAVE_WD, S_DIV_DOY, S_WAIT_DOY, S_WEEK, S_EMIT
  } state_t;

  typedef enum logic [4:0] {
    C_NOP, C_CAPTURE, C_LOAD, C_YADD, C_DN_ADD, C_DN_NEXT, C_SET_ERR,
    C_DIV_YR, C_YEAR, C_MSTEP, C_SETDAY, C_DIV_N, C_SKIP, C_MT, C_DIV_MON,
    C_MSET, C_OUT_DN, C_SAVE_WD, C_DIV_DOY, C_WEEK, C_EMIT
  } cmd_t;

  typedef struct packed {
    logic [2:0] req;
    logic       div_done;
    logic       range_bad;
    logic       t_neg;
    logic       walk_done;
    logic       out_valid;
  } dp_stat_t;

  localparam logic [8:0] DBM [12] = '{9'd0, 9'd31, 9'd59, 9'd90, 9'd120, 9'd151,
                                      9'd181, 9'd212, 9'd243, 9'd273, 9'd304, 9'd334};

  function automatic logic [4:0] mlen(logic [13:0] y, logic [3:0] m);
    logic [4:0] len;
    case (m)
      4'd2:                       len = (y[1:0] == 2'd0) ? 5'd29 : 5'd28;
      4'd4, 4'd6, 4'd9, 4'd11:    len = 5'd30;
      default:                    len = 5'd31;
    endcase
    return len;
  endfunction

  // day of year, 0 for January 1
  function automatic logic [8:0] doy(logic [13:0] y, logic [3:0] m, logic [4:0] d);
    logic [3:0] mi;
    logic [8:0] v;
    mi = (m >= 4'd1 && m <= 4'd12) ? m - 4'd1 : 4'd0;
    v  = DBM[mi] + 9'(d) - 9'd1;
    if (mi >= 4'd2 && y[1:0] == 2'd0) v = v + 9'd1;
    return v;
  endfunction

  function automatic logic [NW-1:0] day_num(logic [13:0] y, logic [3:0] m, logic [4:0] d);
    logic [NW-1:0] ys;
    ys = NW'(y) * NW'(365) + NW'((15'(y) + 15'd3) >> 2);
    return ys + NW'(doy(y, m, d));
  endfunction

endpackage

// ----- src/cda_div.sv -----
// Shared constant divider for 7, 12 and 1461 by reciprocal multiplication.
// Registers the operands on start, then the quotient, then the remainder with done; depends on cda_pkg.
module cda_div (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  input  logic [cda_pkg::NW-1:0] dividend,
  input  logic [10:0]           divisor,
  output logic                  done,
  output logic [cda_pkg::NW-1:0] quo,
  output logic [10:0]           rem
);
  import cda_pkg::*;

  localparam int QW = NW + 11;

  logic [NW-1:0] a_r, a_nxt, q_r, q_nxt;
  logic [10:0]   dvs_r, dvs_nxt, rem_r, rem_nxt;
  logic          mul_r, mul_nxt, sub_r, sub_nxt, done_r, done_nxt;
  logic [23:0]   recip;
  logic [5:0]    shift;
  logic [47:0]   prod;
  logic [QW-1:0] qd;

  // reciprocals are exact for every dividend below 2**23
  always_comb begin
    case (dvs_r)
      11'd12: begin
        recip = 24'd11184811;
        shift = 6'd27;
      end
      11'd1461: begin
        recip = 24'd5879490;
        shift = 6'd33;
      end
      default: begin
        recip = 24'd9586981;
        shift = 6'd26;
      end
    endcase
  end

  assign prod = 48'(a_r) * 48'(recip);
  assign qd   = QW'(q_r) * QW'(dvs_r);

  always_comb begin
    a_nxt    = a_r;
    dvs_nxt  = dvs_r;
    q_nxt    = q_r;
    rem_nxt  = rem_r;
    mul_nxt  = 1'b0;
    sub_nxt  = 1'b0;
    done_nxt = done_r;
    if (start) begin
      a_nxt    = dividend;
      dvs_nxt  = divisor;
      mul_nxt  = 1'b1;
      done_nxt = 1'b0;
    end else if (mul_r) begin
      q_nxt   = NW'(prod >> shift);
      sub_nxt = 1'b1;
    end else if (sub_r) begin
      rem_nxt  = 11'(QW'(a_r) - qd);
      done_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    a_r   <= a_nxt;
    dvs_r <= dvs_nxt;
    q_r   <= q_nxt;
    rem_r <= rem_nxt;
    if (!rst_n) begin
      mul_r  <= 1'b0;
      sub_r  <= 1'b0;
      done_r <= 1'b0;
    end else begin
      mul_r  <= mul_nxt;
      sub_r  <= sub_nxt;
      done_r <= done_nxt;
    end
  end

  assign done = done_r;
  assign quo  = q_r;
  assign rem  = rem_r;

endmodule

// ----- src/cda_dp.sv -----
// Datapath: date registers, day-number arithmetic, month walk and output register.
// Depends on cda_pkg and cda_div; driven by commands from cda_ctrl.
module cda_dp #(
  parameter int MAX_YEAR = 9999
) (
  input  logic              clk,
  input  logic              rst_n,
  input  cda_pkg::cmd_t     cmd,
  output cda_pkg::dp_stat_t stat,
  input  logic [47:0]       in_tdata,
  input  logic [2:0]        in_tuser,
  input  logic              out_tready,
  output logic              out_tvalid,
  output logic [31:0]       out_tdata,
  output logic [1:0]        out_tuser
);
  import cda_pkg::*;

  localparam int LAST = 365 * (MAX_YEAR + 1) + (MAX_YEAR + 4) / 4 - 1;

  logic [2:0]           req_r, req_nxt;
  logic signed [NW-1:0] amt_r, amt_nxt;
  logic [13:0]          ly_r, ly_nxt, y_r, y_nxt;
  logic [3:0]           lm_r, lm_nxt, m_r, m_nxt;
  logic [4:0]           ld_r, ld_nxt, d_r, d_nxt;
  logic signed [SW-1:0] n_r, n_nxt;
  logic [10:0]          r_r, r_nxt;
  logic [8:0]           doy_r, doy_nxt;
  logic [2:0]           wd_r, wd_nxt;
  logic [5:0]           wk_r, wk_nxt;
  logic [1:0]           st_r, st_nxt;
  logic [31:0]          od_r, od_nxt;
  logic [1:0]           ou_r, ou_nxt;
  logic                 ov_r, ov_nxt;

  logic                 div_start, div_done;
  logic [NW-1:0]        div_a, div_q;
  logic [10:0]          div_b, div_rm;

  logic signed [SW-1:0] ny_s;
  logic [24:0]          t_u;
  logic [10:0]          r2;
  logic [13:0]          yq;
  logic [3:0]           mq;
  logic [4:0]           lenq, feb_old, feb_new;

  cda_div u_div (
    .clk(clk), .rst_n(rst_n), .start(div_start), .dividend(div_a), .divisor(div_b),
    .done(div_done), .quo(div_q), .rem(div_rm)
  );

  always_comb begin
    div_start = 1'b0;
    div_a     = n_r[NW-1:0];
    div_b     = 11'd7;
    case (cmd)
      C_DIV_N:   begin div_start = 1'b1; div_a = NW'(n_r + SW'(5)); end
      C_DIV_YR:  begin div_start = 1'b1; div_b = 11'd1461; end
      C_DIV_MON: begin div_start = 1'b1; div_b = 11'd12; end
      C_DIV_DOY: begin div_start = 1'b1; div_a = NW'(doy_r); end
      default:   div_start = 1'b0;
    endcase
  end

  assign ny_s    = $signed({11'd0, y_r}) + SW'(amt_r);
  assign t_u     = 25'(y_r) * 25'd12 + 25'(m_r) - 25'd1;
  assign r2      = div_rm - 11'd366;
  assign yq      = div_q[13:0];
  assign mq      = div_rm[3:0] + 4'd1;
  assign lenq    = mlen(yq, mq);
  assign feb_old = mlen(y_r, 4'd2);
  assign feb_new = mlen(ny_s[13:0], 4'd2);

  always_comb begin
    req_nxt = req_r; amt_nxt = amt_r; ly_nxt = ly_r; lm_nxt = lm_r; ld_nxt = ld_r;
    y_nxt = y_r; m_nxt = m_r; d_nxt = d_r; n_nxt = n_r; r_nxt = r_r;
    doy_nxt = doy_r; wd_nxt = wd_r; wk_nxt = wk_r; st_nxt = st_r;
    od_nxt = od_r; ou_nxt = ou_r;
    ov_nxt = (ov_r && !out_tready);
    case (cmd)
      C_CAPTURE: begin
        req_nxt = in_tuser;
        amt_nxt = $signed(in_tdata[22:0]);
        ly_nxt  = in_tdata[36:23];
        lm_nxt  = in_tdata[40:37];
        ld_nxt  = in_tdata[45:41];
        st_nxt  = ST_OK;
      end
      C_LOAD: begin
        if (lm_r < 4'd1 || lm_r > 4'd12 || ld_r == 5'd0 || ld_r > mlen(ly_r, lm_r))
          st_nxt = ST_BADDATE;
        else if (32'(ly_r) > MAX_YEAR)
          st_nxt = ST_RANGE;
        else begin
          y_nxt = ly_r; m_nxt = lm_r; d_nxt = ld_r;
        end
      end
      C_YADD: begin
        if (ny_s < 0 || ny_s > $signed(SW'(MAX_YEAR)))
          st_nxt = ST_RANGE;
        else begin
          // keep the last day of February at the last day
          if (m_r == 4'd2 && d_r == feb_old) d_nxt = feb_new;
          y_nxt = ny_s[13:0];
        end
      end
      C_DN_ADD:  n_nxt = $signed({2'b00, day_num(y_r, m_r, d_r)}) + SW'(amt_r);
      C_DN_NEXT: n_nxt = $signed({2'b00, day_num(y_r, m_r, d_r)}) + SW'(1);
      C_SET_ERR: st_nxt = ST_RANGE;
      C_YEAR: begin
        y_nxt = {div_q[11:0], 2'b00};
        m_nxt = 4'd1;
        r_nxt = div_rm;
        if (div_rm >= 11'd366) begin
          if (r2 >= 11'd730) begin
            y_nxt = {div_q[11:0], 2'b11}; r_nxt = r2 - 11'd730;
          end else if (r2 >= 11'd365) begin
            y_nxt = {div_q[11:0], 2'b10}; r_nxt = r2 - 11'd365;
          end else begin
            y_nxt = {div_q[11:0], 2'b01}; r_nxt = r2;
          end
        end
      end
      C_MSTEP: begin
        r_nxt = r_r - 11'(mlen(y_r, m_r));
        m_nxt = m_r + 4'd1;
      end
      C_SETDAY: d_nxt = 5'(r_r + 11'd1);
      C_SKIP: begin
        // step over Saturday and Sunday
        if (div_rm[2:0] == 3'd6)      n_nxt = n_r + SW'(2);
        else if (div_rm[2:0] == 3'd0) n_nxt = n_r + SW'(1);
      end
      C_MT: n_nxt = $signed(t_u) + SW'(amt_r);
      C_MSET: begin
        if (32'(div_q) > MAX_YEAR)
          st_nxt = ST_RANGE;
        else begin
          y_nxt = yq;
          m_nxt = mq;
          d_nxt = (d_r > lenq) ? lenq : d_r;
        end
      end
      C_OUT_DN: begin
        n_nxt   = $signed({2'b00, day_num(y_r, m_r, d_r)});
        doy_nxt = doy(y_r, m_r, d_r);
      end
      C_SAVE_WD: wd_nxt = div_rm[2:0];
      C_WEEK:    wk_nxt = 6'(div_q) + 6'd1 + 6'(div_rm[2:0] > wd_r);
      C_EMIT: begin
        od_nxt = {wk_r, wd_r, d_r, m_r, y_r};
        ou_nxt = st_r;
        ov_nxt = 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    req_r <= req_nxt; amt_r <= amt_nxt; ly_r <= ly_nxt; lm_r <= lm_nxt; ld_r <= ld_nxt;
    n_r <= n_nxt; r_r <= r_nxt; doy_r <= doy_nxt; wd_r <= wd_nxt; wk_r <= wk_nxt;
    st_r <= st_nxt; od_r <= od_nxt; ou_r <= ou_nxt;
    if (!rst_n) begin
      y_r  <= 14'd2001;
      m_r  <= 4'd1;
      d_r  <= 5'd1;
      ov_r <= 1'b0;
    end else begin
      y_r  <= y_nxt;
      m_r  <= m_nxt;
      d_r  <= d_nxt;
      ov_r <= ov_nxt;
    end
  end

  always_comb begin
    stat.req       = req_r;
    stat.div_done  = div_done;
    stat.range_bad = (n_r < 0) || (n_r > $signed(SW'(LAST)));
    stat.t_neg     = (n_r < 0);
    stat.walk_done = (m_r == 4'd12) || (r_r < 11'(mlen(y_r, m_r)));
    stat.out_valid = ov_r;
  end

  assign out_tvalid = ov_r;
  assign out_tdata  = od_r;
  assign out_tuser  = ou_r;

endmodule

// ----- src/cda_ctrl.sv -----
// Controller: sequences one request through the datapath by commands.
// Depends on cda_pkg; status comes back from cda_dp.
module cda_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  input  logic              out_tready,
  input  cda_pkg::dp_stat_t stat,
  output cda_pkg::cmd_t     cmd
);
  import cda_pkg::*;

  state_t state_r, state_nxt;
  logic   emit_ok;

  assign emit_ok = !stat.out_valid || out_tready;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE:     if (in_tvalid) state_nxt = S_DISPATCH;
      S_DISPATCH: begin
        case (stat.req)
          REQ_LOAD:   state_nxt = S_LOAD;
          REQ_DAYS:   state_nxt = S_DN_ADD;
          REQ_MONTHS: state_nxt = S_MT;
          REQ_YEARS:  state_nxt = S_YADD;
          REQ_NEXTWD: state_nxt = S_DN_NEXT;
          default:    state_nxt = S_OUT_DN;
        endcase
      end
      S_LOAD, S_YADD: state_nxt = S_OUT_DN;
      S_DN_ADD:   state_nxt = S_RANGE;
      S_RANGE:    state_nxt = stat.range_bad ? S_OUT_DN : S_DIV_YR;
      S_DIV_YR:   state_nxt = S_WAIT_YR;
      S_WAIT_YR:  if (stat.div_done) state_nxt = S_YEAR;
      S_YEAR:     state_nxt = S_MWALK;
      S_MWALK:    if (stat.walk_done) state_nxt = S_OUT_DN;
      S_DN_NEXT:  state_nxt = S_DIV_WD;
      S_DIV_WD:   state_nxt = S_WAIT_WD;
      S_WAIT_WD:  if (stat.div_done) state_nxt = S_SKIP;
      S_SKIP:     state_nxt = S_RANGE;
      S_MT:       state_nxt = S_MCHK;
      S_MCHK:     state_nxt = stat.t_neg ? S_OUT_DN : S_DIV_MON;
      S_DIV_MON:  state_nxt = S_WAIT_MON;
      S_WAIT_MON: if (stat.div_done) state_nxt = S_MSET;
      S_MSET:     state_nxt = S_OUT_DN;
      S_OUT_DN:   state_nxt = S_DIV_OWD;
      S_DIV_OWD:  state_nxt = S_WAIT_OWD;
      S_WAIT_OWD: if (stat.div_done) state_nxt = S_SAVE_WD;
      S_SAVE_WD:  state_nxt = S_DIV_DOY;
      S_DIV_DOY:  state_nxt = S_WAIT_DOY;
      S_WAIT_DOY: if (stat.div_done) state_nxt = S_WEEK;
      S_WEEK:     state_nxt = S_EMIT;
      S_EMIT:     if (emit_ok) state_nxt = S_IDLE;
      default:    state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    cmd       = C_NOP;
    in_tready = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) cmd = C_CAPTURE;
      end
      S_LOAD:    cmd = C_LOAD;
      S_YADD:    cmd = C_YADD;
      S_DN_ADD:  cmd = C_DN_ADD;
      S_DN_NEXT: cmd = C_DN_NEXT;
      S_RANGE:   if (stat.range_bad) cmd = C_SET_ERR;
      S_DIV_YR:  cmd = C_DIV_YR;
      S_YEAR:    cmd = C_YEAR;
      S_MWALK:   cmd = stat.walk_done ? C_SETDAY : C_MSTEP;
      S_DIV_WD:  cmd = C_DIV_N;
      S_SKIP:    cmd = C_SKIP;
      S_MT:      cmd = C_MT;
      S_MCHK:    if (stat.t_neg) cmd = C_SET_ERR;
      S_DIV_MON: cmd = C_DIV_MON;
      S_MSET:    cmd = C_MSET;
      S_OUT_DN:  cmd = C_OUT_DN;
      S_DIV_OWD: cmd = C_DIV_N;
      S_SAVE_WD: cmd = C_SAVE_WD;
      S_DIV_DOY: cmd = C_DIV_DOY;
      S_WEEK:    cmd = C_WEEK;
      S_EMIT:    if (emit_ok) cmd = C_EMIT;
      default:   cmd = C_NOP;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// ----- src/calendar_date_arithmetic.sv -----
// Top level of the calendar date arithmetic block: controller plus datapath.
// Depends on cda_pkg, cda_ctrl, cda_dp (and cda_div inside the datapath).
//
//  channel | direction | tdata                                   | tuser
//  in_     | slave     | amount, load_year, load_month, load_day | req_type
//  out_    | master    | cur_year, cur_month, cur_day, weekday,  | status
//          |           | week_number                             |
//
// One request at a time. The shared constant divider is used once for the weekday,
// once for the week number and once or twice more for day or month arithmetic;
// arithmetic on days, including the weekday step, adds a walk through the months.
// Reset (rst_n low, synchronous) sets the date to 2001-01-01 and empties the
// output register. A stalled result holds in the output register while the
// next request is already taken and worked on.
module calendar_date_arithmetic #(
  parameter int MAX_YEAR = 9999
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [47:0] in_tdata,   // amount[22:0], load_year[36:23], load_month[40:37],
                                  // load_day[45:41], zero fill
  input  logic [2:0]  in_tuser,   // req_type[2:0]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // cur_year[13:0], cur_month[17:14], cur_day[22:18],
                                  // weekday[25:23], week_number[31:26]
  output logic [1:0]  out_tuser   // status[1:0]
);
  import cda_pkg::*;

  cmd_t     cmd;
  dp_stat_t stat;

  cda_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .in_tvalid(in_tvalid), .in_tready(in_tready),
    .out_tready(out_tready), .stat(stat), .cmd(cmd)
  );

  cda_dp #(.MAX_YEAR(MAX_YEAR)) u_dp (
    .clk(clk), .rst_n(rst_n), .cmd(cmd), .stat(stat), .in_tdata(in_tdata),
    .in_tuser(in_tuser), .out_tready(out_tready), .out_tvalid(out_tvalid),
    .out_tdata(out_tdata), .out_tuser(out_tuser)
  );

endmodule

// ----- src/cda_chk.sv -----
// Port-level checker for calendar_date_arithmetic, attached by bind.
// Depends on nothing but the top level's ports.
module cda_chk (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [31:0] out_tdata,
  input logic [1:0]  out_tuser
);

  // a result never shows a status code outside the three defined
  a_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tuser != 2'd3) else $error("bad status code");

  // the held date has a month of 1 to 12, a nonzero day, a weekday of 0 to 6 and a nonzero week
  a_date: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[17:14] != 4'd0 && out_tdata[17:14] <= 4'd12 &&
                    out_tdata[22:18] != 5'd0 && out_tdata[25:23] <= 3'd6 &&
                    out_tdata[31:26] != 6'd0)) else $error("bad date on output");

  // a stalled transfer stays offered
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid) else $error("result dropped");

  // one request at a time: never ready straight after a transfer in
  a_one: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready) else $error("request taken while busy");

  // no result straight out of reset
  a_rst: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid) else $error("output valid after reset");

endmodule

bind calendar_date_arithmetic cda_chk u_cda_chk (.*);

// ----- tb/calendar_date_arithmetic_tb.sv -----
// Self-checking bench for calendar_date_arithmetic: random and directed date requests,
// results predicted in-bench, compared whole and shown field by field on a mismatch. Depends on cda_pkg and the RTL.
module calendar_date_arithmetic_tb;
  import cda_pkg::*;

  localparam int MAXY = 9999;
  localparam int WATCHDOG = 20000;

  typedef struct packed {
    logic [2:0]  req;
    logic [22:0] amount;
    logic [13:0] ly;
    logic [3:0]  lm;
    logic [4:0]  ld;
  } date_req_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [5:0]  week;
    logic [2:0]  wday;
    logic [4:0]  day;
    logic [3:0]  month;
    logic [13:0] year;
  } date_res_t;

  logic        clk = 0;
  logic        rst_n = 0;
  logic        in_tvalid = 0;
  logic        in_tready;
  logic [47:0] in_tdata = '0;
  logic [2:0]  in_tuser = '0;
  logic        out_tvalid;
  logic        out_tready = 0;
  logic [31:0] out_tdata;
  logic [1:0]  out_tuser;

  calendar_date_arithmetic #(.MAX_YEAR(MAXY)) dut (.*);

  always begin
    #5 clk = 1;
    #5 clk = 0;
  end

  date_req_t pending_reqs[$];
  date_res_t expected_dates[$];
  int  errors = 0;
  int  send_idle = 36, recv_idle = 65;
  bit  hold_send = 0;
  int  quiet = 0;
  int  in_acc = 0;       // transfers in, counted by the monitor
  int  in_acc_seen = 0;  // count the driver last acted on

  // calendar state mirrored in the bench
  longint hold_y, hold_m, hold_d;

  function automatic bit leap(longint y);
    return (y % 4) == 0;
  endfunction

  function automatic longint mon_len(longint y, longint m);
    if (m == 2) return leap(y) ? 29 : 28;
    if (m == 4 || m == 6 || m == 9 || m == 11) return 30;
    return 31;
  endfunction

  function automatic longint jan1(longint y);
    return 365 * y + (y + 3) / 4;
  endfunction

  function automatic longint abs_day(longint y, longint m, longint d);
    longint n;
    n = jan1(y) + d - 1;
    for (int i = 1; i < m; i++) n += mon_len(y, longint'(i));
    return n;
  endfunction

  function automatic longint dow(longint n);
    return (n + 5) % 7;
  endfunction

  function automatic void from_abs(longint n);
    longint y, r, m;
    y = (n / 1461) * 4;
    r = n % 1461;
    m = 1;
    if (r >= 366) begin
      y += 1 + (r - 366) / 365;
      r = (r - 366) % 365;
    end
    while (m < 12 && r >= mon_len(y, m)) begin
      r -= mon_len(y, m);
      m++;
    end
    hold_y = y; hold_m = m; hold_d = r + 1;
  endfunction

  function automatic date_res_t apply_request(date_req_t q);
    date_res_t r;
    longint amt, n, t, ny, last, j1, qy, qm, qd;
    logic [1:0] st;
    st = ST_OK;
    amt = longint'($signed(q.amount));
    qy = longint'(q.ly);
    qm = longint'(q.lm);
    qd = longint'(q.ld);
    last = jan1(MAXY + 1) - 1;
    case (q.req)
      REQ_LOAD: begin
        if (qm < 1 || qm > 12 || qd < 1 || qd > mon_len(qy, qm)) st = ST_BADDATE;
        else if (qy > MAXY) st = ST_RANGE;
        else begin
          hold_y = qy; hold_m = qm; hold_d = qd;
        end
      end
      REQ_DAYS: begin
        n = abs_day(hold_y, hold_m, hold_d) + amt;
        if (n < 0 || n > last) st = ST_RANGE;
        else from_abs(n);
      end
      REQ_MONTHS: begin
        t = hold_y * 12 + hold_m - 1 + amt;
        if (t < 0 || t / 12 > MAXY) st = ST_RANGE;
        else begin
          hold_y = t / 12;
          hold_m = t % 12 + 1;
          if (hold_d > mon_len(hold_y, hold_m)) hold_d = mon_len(hold_y, hold_m);
        end
      end
      REQ_YEARS: begin
        ny = hold_y + amt;
        if (ny < 0 || ny > MAXY) st = ST_RANGE;
        else begin
          if (hold_m == 2 && hold_d == mon_len(hold_y, 2)) hold_d = mon_len(ny, 2);
          hold_y = ny;
        end
      end
      REQ_NEXTWD: begin
        n = abs_day(hold_y, hold_m, hold_d) + 1;
        while (dow(n) == 0 || dow(n) == 6) n++;
        if (n > last) st = ST_RANGE;
        else from_abs(n);
      end
      default: ;
    endcase
    n = abs_day(hold_y, hold_m, hold_d);
    j1 = jan1(hold_y);
    r.year = 14'(hold_y); r.month = 4'(hold_m); r.day = 5'(hold_d);
    r.wday = 3'(dow(n));
    r.week = 6'(1 + (n - j1) / 7 + (dow(j1) > dow(n) ? 1 : 0));
    r.status = st;
    return r;
  endfunction

  // driver: present at the falling edge, transfer at the rising edge
  always @(negedge clk) begin
    if (rst_n) begin
      if (!in_tvalid || in_acc != in_acc_seen) begin
        in_acc_seen = in_acc;
        if (pending_reqs.size() > 0 && !hold_send && $urandom_range(99) >= send_idle) begin
          in_tvalid <= 1;
          in_tdata  <= {2'b0, pending_reqs[0].ld, pending_reqs[0].lm, pending_reqs[0].ly,
                        pending_reqs[0].amount};
          in_tuser  <= pending_reqs[0].req;
        end else begin
          in_tvalid <= 0;
        end
      end
      out_tready <= ($urandom_range(99) >= recv_idle);
    end
  end

  // monitor
  always @(posedge clk) begin
    date_res_t got, want;
    if (rst_n) begin
      quiet <= quiet + 1;
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) quiet <= 0;
      if (out_tvalid && out_tready) begin
        got = {out_tuser, out_tdata};
        if (expected_dates.size() == 0) begin
          $display("%0t: unexpected result, expected nothing, actual %h", $realtime, got);
          errors++;
        end else begin
          want = expected_dates.pop_front();
          if (got !== want) begin
            $display("%0t: mismatch expected y%0d m%0d d%0d wd%0d wk%0d st%0d",
                     $realtime, want.year, want.month, want.day, want.wday, want.week,
                     want.status);
            $display("%0t:          actual   y%0d m%0d d%0d wd%0d wk%0d st%0d",
                     $realtime, got.year, got.month, got.day, got.wday, got.week,
                     got.status);
            errors++;
          end
        end
      end
      if (in_tvalid && in_tready) begin
        expected_dates.push_back(apply_request(pending_reqs.pop_front()));
        in_acc++;
      end
      if (quiet >= WATCHDOG) begin
        $display("status: fail");
        $finish;
      end
    end
  end

  function automatic date_req_t mk(logic [2:0] rq, int amt, int y, int m, int d);
    date_req_t q;
    q.req = rq; q.amount = amt[22:0]; q.ly = 14'(y); q.lm = 4'(m); q.ld = 5'(d);
    return q;
  endfunction

  function automatic date_req_t rand_req();
    date_req_t q;
    int k;
    q = mk(3'($urandom_range(4)), 0, int'($urandom_range(9999)),
           int'($urandom_range(1, 12)), int'($urandom_range(1, 31)));
    k = $urandom_range(9);
    case (q.req)
      REQ_DAYS:   q.amount = (k < 6) ? 23'($urandom_range(0, 800) - 400) :
                             (k < 9) ? 23'($urandom_range(0, 2000000) - 1000000) :
                                       23'($urandom);
      REQ_MONTHS: q.amount = (k < 7) ? 23'($urandom_range(0, 60) - 30) :
                             (k < 9) ? 23'($urandom_range(0, 240000) - 120000) :
                                       23'($urandom);
      REQ_YEARS:  q.amount = (k < 7) ? 23'($urandom_range(0, 20) - 10) :
                             (k < 9) ? 23'($urandom_range(0, 20000) - 10000) :
                                       23'($urandom);
      REQ_LOAD: begin
        if (k == 0) begin
          q.ly = 14'($urandom); q.lm = 4'($urandom); q.ld = 5'($urandom);
        end
        q.amount = 23'($urandom);
      end
      default: begin
        q.amount = 23'($urandom);
        if (k == 0) q.req = 3'($urandom_range(5, 7));
      end
    endcase
    return q;
  endfunction

  task automatic wait_drained();
    while (pending_reqs.size() > 0 || in_tvalid || expected_dates.size() > 0) @(posedge clk);
  endtask

  initial begin
    hold_y = 2001; hold_m = 1; hold_d = 1;
    repeat (3) @(posedge clk);
    rst_n <= 1;
    // directed: extremes, leap day, bad loads, range errors, unused codes
    pending_reqs.push_back(mk(REQ_DAYS, 0, 0, 1, 1));
    pending_reqs.push_back(mk(REQ_LOAD, 0, 0, 1, 1));
    pending_reqs.push_back(mk(REQ_DAYS, -1, 0, 1, 1));
    pending_reqs.push_back(mk(REQ_LOAD, 0, 9999, 12, 31));
    pending_reqs.push_back(mk(REQ_NEXTWD, 0, 0, 1, 1));
    pending_reqs.push_back(mk(REQ_DAYS, -4194304, 0, 1, 1));
    pending_reqs.push_back(mk(REQ_DAYS, 4194303, 0, 1, 1));
    pending_reqs.push_back(mk(REQ_LOAD, 0, 2004, 2, 29));
    pending_reqs.push_back(mk(REQ_YEARS, 1, 0, 1, 1));
    pending_reqs.push_back(mk(REQ_YEARS, 3, 0, 1, 1));
    pending_reqs.push_back(mk(REQ_LOAD, 0, 2003, 1, 31));
    pending_reqs.push_back(mk(REQ_MONTHS, 1, 0, 1, 1));
    pending_reqs.push_back(mk(REQ_MONTHS, -4194304, 0, 1, 1));
    pending_reqs.push_back(mk(REQ_YEARS, 4194303, 0, 1, 1));
    pending_reqs.push_back(mk(REQ_LOAD, 0, 2003, 2, 29));
    pending_reqs.push_back(mk(REQ_LOAD, 0, 2003, 13, 1));
    pending_reqs.push_back(mk(REQ_LOAD, 0, 2003, 0, 5));
    pending_reqs.push_back(mk(REQ_LOAD, 0, 2003, 15, 0));
    pending_reqs.push_back(mk(REQ_LOAD, 0, 16383, 6, 15));
    pending_reqs.push_back(mk(REQ_LOAD, 0, 2024, 3, 1));
    pending_reqs.push_back(mk(REQ_NEXTWD, 0, 0, 1, 1));
    pending_reqs.push_back(mk(3'd5, 7, 1, 1, 1));
    pending_reqs.push_back(mk(3'd7, -1, 16383, 15, 31));
    wait_drained();
    for (int phase = 0; phase < 3; phase++) begin
      send_idle = (phase == 0) ? 36 : (phase == 1) ? 65 : 0;
      recv_idle = (phase == 0) ? 65 : (phase == 1) ? 36 : 0;
      for (int i = 0; i < 530; i++) begin
        pending_reqs.push_back(rand_req());
        // hold the sender once until every result is back
        if (phase == 1 && i == 100) begin
          hold_send = 1;
          while (in_tvalid || expected_dates.size() > 0) @(posedge clk);
          hold_send = 0;
        end
      end
      wait_drained();
    end
    repeat (200) @(posedge clk);
    if (errors == 0) $display("status: pass");
    else $display("status: fail");
    $finish;
  end

endmodule

// ----- sim.f -----
src/cda_pkg.sv
src/cda_div.sv
src/cda_dp.sv
src/cda_ctrl.sv
src/calendar_date_arithmetic.sv
src/cda_chk.sv
tb/calendar_date_arithmetic_tb.sv
